// File: src/bis_pkg.sv
// Shared constants, codes and types for the bounded integer stack.
package bis_pkg;

  // Storage geometry
  localparam int DEPTH  = 64;
  localparam int ADDR_W = 6;
  localparam int CNT_W  = 7;
  localparam int WORD_W = 32;

  // Request codes carried on s_tuser
  localparam logic [2:0] ACT_PUSH   = 3'd0;
  localparam logic [2:0] ACT_POP    = 3'd1;
  localparam logic [2:0] ACT_PEEK   = 3'd2;
  localparam logic [2:0] ACT_CLEAR  = 3'd3;
  localparam logic [2:0] ACT_SEARCH = 3'd4;

  // Result beat layout on m_tdata
  localparam int OUT_W        = 56;
  localparam int OUT_OK       = 0;
  localparam int OUT_DATA_LO  = 1;
  localparam int OUT_FOUND    = 33;
  localparam int OUT_IDX_LO   = 34;
  localparam int OUT_CNT_LO   = 40;
  localparam int OUT_EMPTY    = 47;
  localparam int OUT_FULL     = 48;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RWAIT,
    ST_SRD,
    ST_SCMP,
    ST_DONE
  } state_t;

  // Request from the sequencer to the entry memory
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } mem_req_t;

  // Per-request result fields held by the sequencer
  typedef struct packed {
    logic              ok;
    logic [WORD_W-1:0] data;
    logic              found;
    logic [ADDR_W-1:0] idx;
  } result_t;

endpackage

// File: src/bounded_int_stack.sv
// Top level of the bounded integer stack: ports, capacity register, result beat register.
//
//  channel | direction | beat contents
//  s_*     | in        | tuser: action[2:0]; tdata: value[31:0]
//  m_*     | out       | tdata: ok, data, found, match_index, count, empty_res, full_res
//  cfg_*   | in        | cfg_wdata: capacity[6:0], written when cfg_we is high
//
// Every beat passes idle, execute and result handoff; a pop or peek on a non-empty stack adds
// one registered memory read. A search scans the entries from the top down, one read and one
// key compare per entry, until the key is found or every entry has been scanned.
// s_tready is high only when the sequencer is idle; a result held in the output register
// frees the sequencer, but the next result then waits in its done state, s_tready low, until m_tready.
// Reset (rst, synchronous) empties the stack and sets capacity to 64; entries stay as is.
module bounded_int_stack (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [31:0]                 s_tdata,   // value[31:0]
  input  logic [2:0]                  s_tuser,   // action[2:0]
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // ok[0], data[32:1], found[33], match_index[39:34], count[46:40],
  // empty_res[47], full_res[48], zero[55:49]
  output logic [bis_pkg::OUT_W-1:0]   m_tdata,
  input  logic                        cfg_we,
  input  logic [6:0]                  cfg_wdata
);

  logic [bis_pkg::CNT_W-1:0]  capacity;
  logic [bis_pkg::CNT_W-1:0]  cap_eff;
  bis_pkg::mem_req_t          mem_req;
  logic [bis_pkg::WORD_W-1:0] mem_rdata;
  logic                       res_valid;
  logic                       res_take;
  bis_pkg::result_t           res;
  logic [bis_pkg::CNT_W-1:0]  count;

  // Hold the capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= bis_pkg::CNT_W'(64);
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // Saturate capacity to the storage depth
  assign cap_eff = (capacity > bis_pkg::CNT_W'(bis_pkg::DEPTH))
                 ? bis_pkg::CNT_W'(bis_pkg::DEPTH) : capacity;

  bis_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_action (s_tuser),
    .in_value  (s_tdata),
    .cap_eff   (cap_eff),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .count     (count)
  );

  bis_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  assign res_take = res_valid && (!m_tvalid || m_tready);

  // Drive the result beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Load the result beat
  always_ff @(posedge clk) begin
    if (res_take) begin
      m_tdata <= {7'd0,
                  (count >= cap_eff),
                  (count == '0),
                  count,
                  res.idx,
                  res.found,
                  res.data,
                  res.ok};
    end
  end

endmodule

// File: src/bis_mem.sv
// Entry memory: one write port and one registered read port.
module bis_mem (
  input  logic                          clk,
  input  bis_pkg::mem_req_t             req,
  output logic [bis_pkg::WORD_W-1:0]    rdata
);

  logic [bis_pkg::WORD_W-1:0] mem [bis_pkg::DEPTH];

  // Write the addressed entry
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

// File: src/bis_ctrl.sv
// Request sequencer: fill count, memory access steps and the shared key compare.
module bis_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_action,
  input  logic [bis_pkg::WORD_W-1:0]    in_value,
  input  logic [bis_pkg::CNT_W-1:0]     cap_eff,
  output bis_pkg::mem_req_t             mem_req,
  input  logic [bis_pkg::WORD_W-1:0]    mem_rdata,
  output logic                          res_valid,
  input  logic                          res_take,
  output bis_pkg::result_t              res,
  output logic [bis_pkg::CNT_W-1:0]     count
);

  bis_pkg::state_t state, state_next;

  logic [2:0]                 act;
  logic [bis_pkg::WORD_W-1:0] key;
  logic [bis_pkg::CNT_W-1:0]  cnt;
  logic [bis_pkg::CNT_W-1:0]  ptr;
  bis_pkg::result_t           r;

  logic can_push;
  logic not_empty;
  logic hit;
  logic ptr_live;

  assign can_push  = (cnt < cap_eff);
  assign not_empty = (cnt != '0);
  assign ptr_live  = (ptr != '0);
  // Shared compare unit, used once per scanned entry
  assign hit       = (mem_rdata == key);

  assign res   = r;
  assign count = cnt;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      bis_pkg::ST_IDLE: begin
        if (in_valid) state_next = bis_pkg::ST_EXEC;
      end
      bis_pkg::ST_EXEC: begin
        unique case (act)
          bis_pkg::ACT_POP, bis_pkg::ACT_PEEK: begin
            state_next = not_empty ? bis_pkg::ST_RWAIT : bis_pkg::ST_DONE;
          end
          bis_pkg::ACT_SEARCH: state_next = bis_pkg::ST_SRD;
          default:             state_next = bis_pkg::ST_DONE;
        endcase
      end
      bis_pkg::ST_RWAIT: state_next = bis_pkg::ST_DONE;
      bis_pkg::ST_SRD: begin
        state_next = ptr_live ? bis_pkg::ST_SCMP : bis_pkg::ST_DONE;
      end
      bis_pkg::ST_SCMP: begin
        state_next = hit ? bis_pkg::ST_DONE : bis_pkg::ST_SRD;
      end
      bis_pkg::ST_DONE: begin
        if (res_take) state_next = bis_pkg::ST_IDLE;
      end
      default: state_next = bis_pkg::ST_IDLE;
    endcase
  end

  // Outputs: handshake and memory requests
  always_comb begin
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.re    = 1'b0;
    mem_req.addr  = cnt[bis_pkg::ADDR_W-1:0];
    mem_req.wdata = key;
    unique case (state)
      bis_pkg::ST_IDLE: in_ready = 1'b1;
      bis_pkg::ST_EXEC: begin
        unique case (act)
          bis_pkg::ACT_PUSH: mem_req.we = can_push;
          bis_pkg::ACT_POP, bis_pkg::ACT_PEEK: begin
            mem_req.re   = not_empty;
            mem_req.addr = bis_pkg::ADDR_W'(cnt - 1'b1);
          end
          default: ;
        endcase
      end
      bis_pkg::ST_SRD: begin
        mem_req.re   = ptr_live;
        mem_req.addr = bis_pkg::ADDR_W'(ptr - 1'b1);
      end
      bis_pkg::ST_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  // Advance the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bis_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Update the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == bis_pkg::ST_EXEC) begin
      if (act == bis_pkg::ACT_PUSH && can_push) cnt <= cnt + 1'b1;
      else if (act == bis_pkg::ACT_CLEAR)       cnt <= '0;
    end else if (state == bis_pkg::ST_RWAIT && act == bis_pkg::ACT_POP) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Capture the request and build the result fields
  always_ff @(posedge clk) begin
    unique case (state)
      bis_pkg::ST_IDLE: begin
        if (in_valid) begin
          act <= in_action;
          key <= in_value;
          r   <= '0;
        end
      end
      bis_pkg::ST_EXEC: begin
        ptr <= cnt;
        unique case (act)
          bis_pkg::ACT_PUSH:   r.ok <= can_push;
          bis_pkg::ACT_CLEAR:  r.ok <= 1'b1;
          bis_pkg::ACT_SEARCH: r.ok <= 1'b1;
          default: ;
        endcase
      end
      bis_pkg::ST_RWAIT: begin
        r.ok   <= 1'b1;
        r.data <= mem_rdata;
      end
      bis_pkg::ST_SRD: begin
        if (ptr_live) ptr <= ptr - 1'b1;
      end
      bis_pkg::ST_SCMP: begin
        if (hit) begin
          r.found <= 1'b1;
          r.idx   <= ptr[bis_pkg::ADDR_W-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

// File: src/bis_checker.sv
// Port-level checks for the bounded integer stack, bound to the top level.
module bis_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [bis_pkg::OUT_W-1:0]  m_tdata
);

  // No result beat right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed");

  // Empty flag follows the reported count
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[bis_pkg::OUT_EMPTY] ==
                 (m_tdata[bis_pkg::OUT_CNT_LO +: bis_pkg::CNT_W] == '0))
    else $error("empty flag disagrees with count");

  // Failed request carries zero data
  a_fail_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[bis_pkg::OUT_OK] |->
      m_tdata[bis_pkg::OUT_DATA_LO +: bis_pkg::WORD_W] == '0)
    else $error("failed request returned data");

  // Index is zero unless the search found the key
  a_idx: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[bis_pkg::OUT_FOUND] |->
      m_tdata[bis_pkg::OUT_IDX_LO +: bis_pkg::ADDR_W] == '0)
    else $error("match index set without a match");

endmodule

bind bounded_int_stack bis_checker u_bis_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: tb/sv/tb_top.sv
// Self-checking testbench for the bounded integer stack: directed and random requests.
module tb_top;
  import bis_pkg::*;

  // Request codes the block leaves unused
  localparam logic [2:0] ACT_SPARE_A = 3'd5;
  localparam logic [2:0] ACT_SPARE_B = 3'd6;
  localparam logic [2:0] ACT_SPARE_C = 3'd7;
  localparam logic [6:0] CAP_TOP     = 7'd127;
  localparam logic [6:0] CAP_FULL    = 7'd64;
  localparam int HOLD_CYCLES      = 400;
  localparam int SETTLE_CYCLES    = 140;   // longer than a search over every entry
  localparam int CYCLE_LIMIT      = 1500000;
  localparam int RANDOM_PER_PHASE = 300;
  localparam int SEGMENT_LEN      = 80;
  localparam int REPORT_LIMIT     = 10;

  // One result beat, field by field
  typedef struct packed {
    logic              ok;
    logic [WORD_W-1:0] data;
    logic              found;
    logic [ADDR_W-1:0] match_index;
    logic [CNT_W-1:0]  count;
    logic              empty_res;
    logic              full_res;
  } reply_t;

  // Stack predictor and reply checker
  class stack_scoreboard;
    logic [WORD_W-1:0] words [DEPTH];
    int unsigned       held;
    logic [CNT_W-1:0]  capacity;
    reply_t            replies [$];
    int unsigned       mismatches;

    function new();
      held = 0;
      capacity = CAP_FULL;
      mismatches = 0;
    endfunction

    function void set_capacity(logic [CNT_W-1:0] cap);
      capacity = cap;
    endfunction

    function int pending();
      return replies.size();
    endfunction

    // Pick a word currently on the stack, so searches hit
    function logic [WORD_W-1:0] live_key();
      if (held == 0) return $urandom;
      return words[$urandom_range(held - 1)];
    endfunction

    // Predict the reply to one accepted request
    function void note_request(logic [2:0] action, logic [WORD_W-1:0] value);
      reply_t      r;
      int unsigned lim;
      int          i;
      r = '0;
      lim = (capacity > DEPTH) ? DEPTH : capacity;
      case (action)
        ACT_PUSH: begin
          if (held < lim) begin
            words[held] = value;
            held++;
            r.ok = 1'b1;
          end
        end
        ACT_POP: begin
          if (held > 0) begin
            held--;
            r.data = words[held];
            r.ok = 1'b1;
          end
        end
        ACT_PEEK: begin
          if (held > 0) begin
            r.data = words[held - 1];
            r.ok = 1'b1;
          end
        end
        ACT_CLEAR: begin
          held = 0;
          r.ok = 1'b1;
        end
        ACT_SEARCH: begin
          r.ok = 1'b1;
          for (i = int'(held) - 1; i >= 0 && !r.found; i--) begin
            if (words[i] == value) begin
              r.found = 1'b1;
              r.match_index = i[ADDR_W-1:0];
            end
          end
        end
        default: ;
      endcase
      r.count = held[CNT_W-1:0];
      r.empty_res = (held == 0);
      r.full_res = (held >= lim);
      replies.push_back(r);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch on %s: expected %h, got %h", name, want, got);
      end
    endfunction

    // Check one accepted result beat against the oldest prediction
    function void check_result(logic [OUT_W-1:0] beat);
      reply_t want;
      if (replies.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch: result beat %h with no request outstanding", beat);
        return;
      end
      want = replies.pop_front();
      compare("ok", want.ok, beat[OUT_OK]);
      compare("data", want.data, beat[OUT_DATA_LO +: WORD_W]);
      compare("found", want.found, beat[OUT_FOUND]);
      compare("match_index", want.match_index, beat[OUT_IDX_LO +: ADDR_W]);
      compare("count", want.count, beat[OUT_CNT_LO +: CNT_W]);
      compare("empty_res", want.empty_res, beat[OUT_EMPTY]);
      compare("full_res", want.full_res, beat[OUT_FULL]);
      compare("padding", 32'd0, beat[OUT_W-1:OUT_FULL+1]);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [31:0]         s_tdata = '0;
  logic [2:0]          s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_W-1:0]    m_tdata;
  logic                cfg_we = 1'b0;
  logic [6:0]          cfg_wdata = '0;

  logic                rx_hold = 1'b0;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;
  int unsigned         cycle_count = 0;
  event                hold_go;
  stack_scoreboard     sb;

  bounded_int_stack i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Clock: period 4
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL bounded_int_stack");
      $finish;
    end
  end

  // Hold off the result side for a long stretch on request
  initial forever begin
    @(hold_go);
    @(posedge clk) rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Drive ready with random stalls
  always @(negedge clk) begin
    m_tready <= rx_hold ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  // Check every accepted result beat
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // Offer one request beat and wait until it is taken
  task automatic send_request(logic [2:0] action, logic [31:0] value);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= action;
    s_tdata <= value;
    do @(posedge clk); while (!s_tready);
    sb.note_request(action, value);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_idle();
    @(negedge clk) s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [6:0] cap);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk) cfg_we <= 1'b0;
    sb.set_capacity(cap);
  endtask

  // Random word, biased toward extremes and a few small repeats
  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      4, 5: return $urandom_range(7);
      default: return $urandom;
    endcase
  endfunction

  // Random requests: alternate push-heavy and pop-heavy segments
  task automatic run_random(int n, bit with_hold);
    logic [2:0]  act;
    logic [31:0] val;
    int          r;
    bit          filling;
    for (int k = 0; k < n; k++) begin
      if (with_hold && k == n / 2) -> hold_go;
      filling = ((k / SEGMENT_LEN) % 2) == 0;
      r = $urandom_range(99);
      val = pick_word();
      if (filling) begin
        if (r < 70) act = ACT_PUSH;
        else if (r < 80) act = ACT_POP;
        else if (r < 85) act = ACT_PEEK;
        else if (r < 97) act = ACT_SEARCH;
        else act = 3'($urandom_range(ACT_SPARE_C, ACT_SPARE_A));
      end else begin
        if (r < 20) act = ACT_PUSH;
        else if (r < 65) act = ACT_POP;
        else if (r < 75) act = ACT_PEEK;
        else if (r < 78) act = ACT_CLEAR;
        else if (r < 97) act = ACT_SEARCH;
        else act = 3'($urandom_range(ACT_SPARE_C, ACT_SPARE_A));
      end
      if (act == ACT_SEARCH && $urandom_range(99) < 65) val = sb.live_key();
      send_request(act, val);
    end
  endtask

  // Main sequence
  initial begin
    logic [6:0] cap;
    sb = new();
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Empty stack, extremes, duplicates, unused codes
    send_request(ACT_POP, 32'h0);
    send_request(ACT_PEEK, 32'h0);
    send_request(ACT_SEARCH, 32'h0);
    send_request(ACT_PUSH, 32'h8000_0000);
    send_request(ACT_PUSH, 32'h7fff_ffff);
    send_request(ACT_PUSH, 32'h0000_0000);
    send_request(ACT_PUSH, 32'hffff_ffff);
    send_request(ACT_PUSH, 32'h7fff_ffff);
    send_request(ACT_PEEK, 32'h0);
    send_request(ACT_SEARCH, 32'h7fff_ffff);
    send_request(ACT_SEARCH, 32'h8000_0000);
    send_request(ACT_SEARCH, 32'h1234_5678);
    send_request(ACT_POP, 32'hffff_ffff);
    send_request(ACT_SPARE_A, 32'h0);
    send_request(ACT_SPARE_B, 32'hffff_ffff);
    send_request(ACT_SPARE_C, 32'h5555_aaaa);
    send_request(ACT_CLEAR, 32'h0);
    send_request(ACT_PEEK, 32'h0);

    // Small capacity: fill, overflow, then lower it below the count
    write_capacity(7'd2);
    send_request(ACT_PUSH, 32'h0000_0001);
    send_request(ACT_PUSH, 32'h0000_0002);
    send_request(ACT_PUSH, 32'h0000_0003);
    write_capacity(7'd1);
    send_request(ACT_PUSH, 32'h0000_0004);
    send_request(ACT_POP, 32'h0);
    send_request(ACT_SEARCH, 32'h0000_0001);

    // Random phases over several capacities and idling patterns
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: cap = CAP_FULL;
        1: cap = CAP_TOP;
        2: cap = 7'd0;
        3: cap = 7'd1;
        4: cap = CAP_FULL;
        default: cap = 7'($urandom_range(63, 2));
      endcase
      write_capacity(cap);
      if (p < 2) begin
        send_idle_pct = 20;
        recv_stall_pct = 75;
      end else if (p < 4) begin
        send_idle_pct = 75;
        recv_stall_pct = 20;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      run_random(RANDOM_PER_PHASE, p == 0 || p == 4);
    end

    // Drain and let any stray beat show up
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS bounded_int_stack");
    end else begin
      $display("FAIL bounded_int_stack");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/bis_pkg.sv
src/bis_mem.sv
src/bis_ctrl.sv
src/bounded_int_stack.sv
src/bis_checker.sv
tb/sv/tb_top.sv
